// File: sv/tmt_pkg.sv
package tmt_pkg;

    localparam int FIELD_COL_W  = 7;
    localparam int FIELD_ROW_W  = 5;
    localparam int CELL_W       = 16;

    typedef enum logic [1:0] {
        REQ_PUT_CURSOR = 2'd0,
        REQ_PUT_AT     = 2'd1,
        REQ_READ       = 2'd2,
        REQ_NONE       = 2'd3
    } tmt_req_t;

    localparam logic [7:0]        NEWLINE_CODE = 8'd10;
    localparam logic [CELL_W-1:0] BLANK_CELL   = 16'h0020;
    localparam logic [CELL_W-1:0] RESET_CELL   = 16'h0720;
    localparam logic [7:0]        RESET_COLOR  = 8'h07;

    typedef struct packed {
        logic [CELL_W-1:0]      read_cell;
        logic [FIELD_COL_W-1:0] cursor_col;
        logic [FIELD_ROW_W-1:0] cursor_row;
        logic                   scrolled;
    } tmt_result_t;

endpackage

// File: sv/tmt_ram.sv
module tmt_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 3200
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            rdata <= mem[raddr];
        end
    end

endmodule

// File: sv/tmt_out_reg.sv
module tmt_out_reg
    import tmt_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        load,
    input  tmt_result_t result,
    output logic        free,
    output logic        m_valid,
    input  logic        m_ready,
    output tmt_result_t m_result
);

    logic        valid_reg;
    tmt_result_t data_reg;

    // The register can take a new word when empty or when its word leaves now.
    assign free     = !valid_reg || m_ready;
    assign m_valid  = valid_reg;
    assign m_result = data_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (load) begin
            valid_reg <= 1'b1;
        end else if (m_ready) begin
            valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (load) begin
            data_reg <= result;
        end
    end

endmodule

// File: sv/tmt_ctrl.sv
module tmt_ctrl
    import tmt_pkg::*;
#(
    parameter int COLS = 80,
    parameter int ROWS = 25,
    parameter int CW   = 7,
    parameter int RW   = 5
) (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   cfg_wr_en,
    input  logic [7:0]             cfg_wr_data,
    input  logic                   s_valid,
    output logic                   s_ready,
    input  logic [1:0]             s_req_type,
    input  logic [7:0]             s_char_code,
    input  logic [7:0]             s_cell_color,
    input  logic [FIELD_COL_W-1:0] s_col,
    input  logic [FIELD_ROW_W-1:0] s_row,
    output logic                   mem_we,
    output logic [RW+CW-1:0]       mem_waddr,
    output logic [CELL_W-1:0]      mem_wdata,
    output logic                   mem_re,
    output logic [RW+CW-1:0]       mem_raddr,
    input  logic [CELL_W-1:0]      mem_rdata,
    input  logic                   out_free,
    output logic                   out_load,
    output tmt_result_t            out_result
);

    localparam int AW = RW + CW;
    localparam int DEPTH = ROWS * (2 ** CW);
    localparam logic [AW-1:0] WIPE_LAST = AW'(DEPTH - 1);
    localparam logic [CW-1:0] COL_LAST  = CW'(COLS - 1);
    localparam logic [RW-1:0] ROW_LAST  = RW'(ROWS - 1);

    typedef enum logic [4:0] {
        ST_WIPE   = 5'b00001,
        ST_IDLE   = 5'b00010,
        ST_READ   = 5'b00100,
        ST_SCROLL = 5'b01000,
        ST_DONE   = 5'b10000
    } state_t;

    state_t        state_reg, state_next;
    logic [AW-1:0] wipe_addr_reg, wipe_addr_next;
    logic [CW-1:0] cur_x_reg, cur_x_next;
    logic [RW-1:0] cur_y_reg, cur_y_next;
    logic [RW-1:0] top_reg, top_next;
    logic [7:0]    color_reg;
    logic [CW-1:0] clr_col_reg, clr_col_next;
    logic [RW-1:0] clr_row_reg, clr_row_next;
    tmt_result_t   res_reg, res_next;

    logic          accept;
    logic          is_put, is_put_at, is_read, is_newline;
    logic          in_range, wrap, scroll;
    logic [RW-1:0] cur_phys, req_phys;

    // Rows are kept in a ring: logical row r lives at physical row (r + top) mod ROWS,
    // so a scroll only moves the top pointer and blanks one row.
    function automatic logic [RW-1:0] phys_row(input logic [RW-1:0] lr,
                                               input logic [RW-1:0] t);
        logic [RW:0] s;
        s = {1'b0, lr} + {1'b0, t};
        if (s >= (RW+1)'(ROWS)) begin
            s = s - (RW+1)'(ROWS);
        end
        return s[RW-1:0];
    endfunction

    assign s_ready    = (state_reg == ST_IDLE);
    assign accept     = s_valid && s_ready;
    assign is_put     = (s_req_type == REQ_PUT_CURSOR);
    assign is_put_at  = (s_req_type == REQ_PUT_AT);
    assign is_read    = (s_req_type == REQ_READ);
    assign is_newline = (s_char_code == NEWLINE_CODE);
    assign in_range   = ({1'b0, s_col} < (FIELD_COL_W+1)'(COLS))
                     && ({1'b0, s_row} < (FIELD_ROW_W+1)'(ROWS));
    assign wrap       = is_put && (is_newline || (cur_x_reg == COL_LAST));
    assign scroll     = wrap && (cur_y_reg == ROW_LAST);
    assign cur_phys   = phys_row(cur_y_reg, top_reg);
    assign req_phys   = phys_row(s_row[RW-1:0], top_reg);

    assign out_load   = (state_reg == ST_DONE) && out_free;
    assign out_result = res_reg;

    always_comb begin
        state_next     = state_reg;
        wipe_addr_next = wipe_addr_reg;
        cur_x_next     = cur_x_reg;
        cur_y_next     = cur_y_reg;
        top_next       = top_reg;
        clr_col_next   = clr_col_reg;
        clr_row_next   = clr_row_reg;
        res_next       = res_reg;
        mem_we         = 1'b0;
        mem_waddr      = {cur_phys, cur_x_reg};
        mem_wdata      = {color_reg, s_char_code};
        mem_re         = 1'b0;
        mem_raddr      = {req_phys, s_col[CW-1:0]};

        case (state_reg)
            ST_WIPE: begin
                mem_we         = 1'b1;
                mem_waddr      = wipe_addr_reg;
                mem_wdata      = RESET_CELL;
                wipe_addr_next = wipe_addr_reg + AW'(1);
                if (wipe_addr_reg == WIPE_LAST) begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE: begin
                if (accept) begin
                    if (is_put) begin
                        mem_we = !is_newline;
                        if (wrap) begin
                            cur_x_next = '0;
                            if (!scroll) begin
                                cur_y_next = cur_y_reg + RW'(1);
                            end
                        end else begin
                            cur_x_next = cur_x_reg + CW'(1);
                        end
                    end else if (is_put_at) begin
                        mem_we    = in_range;
                        mem_waddr = {req_phys, s_col[CW-1:0]};
                        mem_wdata = {s_cell_color, s_char_code};
                    end else if (is_read) begin
                        mem_re = in_range;
                    end

                    res_next.read_cell  = '0;
                    res_next.cursor_col = FIELD_COL_W'(cur_x_next);
                    res_next.cursor_row = FIELD_ROW_W'(cur_y_next);
                    res_next.scrolled   = scroll;

                    if (scroll) begin
                        // The old top row becomes the new bottom row.
                        clr_row_next = top_reg;
                        clr_col_next = '0;
                        top_next     = (top_reg == ROW_LAST) ? '0 : top_reg + RW'(1);
                        state_next   = ST_SCROLL;
                    end else if (is_read && in_range) begin
                        state_next = ST_READ;
                    end else begin
                        state_next = ST_DONE;
                    end
                end
            end
            ST_READ: begin
                res_next.read_cell = mem_rdata;
                state_next         = ST_DONE;
            end
            ST_SCROLL: begin
                mem_we       = 1'b1;
                mem_waddr    = {clr_row_reg, clr_col_reg};
                mem_wdata    = BLANK_CELL;
                clr_col_next = clr_col_reg + CW'(1);
                if (clr_col_reg == COL_LAST) begin
                    state_next = ST_DONE;
                end
            end
            ST_DONE: begin
                if (out_free) begin
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_WIPE;
            wipe_addr_reg <= '0;
            cur_x_reg     <= '0;
            cur_y_reg     <= '0;
            top_reg       <= '0;
            color_reg     <= RESET_COLOR;
        end else begin
            state_reg     <= state_next;
            wipe_addr_reg <= wipe_addr_next;
            cur_x_reg     <= cur_x_next;
            cur_y_reg     <= cur_y_next;
            top_reg       <= top_next;
            if (cfg_wr_en) begin
                color_reg <= cfg_wr_data;
            end
        end
    end

    always_ff @(posedge aclk) begin
        clr_col_reg <= clr_col_next;
        clr_row_reg <= clr_row_next;
        res_reg     <= res_next;
    end

endmodule

// File: sv/text_mode_terminal_cursor_unit.sv
// An accepted word goes from the controller's result register into the output register;
// an in-range read first waits for the screen RAM's registered read data, and a scroll
// first blanks one row of COLS cells at one cell per cycle. A new word is taken only
// after the last word's result has been loaded into the output register, which may stall.
// Reset (synchronous, active low) starts a clearing pass over ROWS * 2**ceil(log2(COLS))
// cells (3200 by default) that fills the screen with 0x0720; s_ready stays low until then.
module text_mode_terminal_cursor_unit
    import tmt_pkg::*;
#(
    parameter int COLS = 80,
    parameter int ROWS = 25
) (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   cfg_wr_en,
    input  logic [7:0]             cfg_wr_data,
    input  logic                   s_valid,
    output logic                   s_ready,
    input  logic [1:0]             s_req_type,
    input  logic [7:0]             s_char_code,
    input  logic [7:0]             s_cell_color,
    input  logic [FIELD_COL_W-1:0] s_col,
    input  logic [FIELD_ROW_W-1:0] s_row,
    output logic                   m_valid,
    input  logic                   m_ready,
    output logic [CELL_W-1:0]      m_read_cell,
    output logic [FIELD_COL_W-1:0] m_cursor_col,
    output logic [FIELD_ROW_W-1:0] m_cursor_row,
    output logic                   m_scrolled
);

    localparam int CW    = $clog2(COLS);
    localparam int RW    = $clog2(ROWS);
    localparam int AW    = RW + CW;
    localparam int DEPTH = ROWS * (2 ** CW);

    logic              mem_we, mem_re;
    logic [AW-1:0]     mem_waddr, mem_raddr;
    logic [CELL_W-1:0] mem_wdata, mem_rdata;
    logic              out_free, out_load;
    tmt_result_t       out_result, m_result;

    tmt_ctrl #(
        .COLS (COLS),
        .ROWS (ROWS),
        .CW   (CW),
        .RW   (RW)
    ) u_ctrl (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .cfg_wr_en    (cfg_wr_en),
        .cfg_wr_data  (cfg_wr_data),
        .s_valid      (s_valid),
        .s_ready      (s_ready),
        .s_req_type   (s_req_type),
        .s_char_code  (s_char_code),
        .s_cell_color (s_cell_color),
        .s_col        (s_col),
        .s_row        (s_row),
        .mem_we       (mem_we),
        .mem_waddr    (mem_waddr),
        .mem_wdata    (mem_wdata),
        .mem_re       (mem_re),
        .mem_raddr    (mem_raddr),
        .mem_rdata    (mem_rdata),
        .out_free     (out_free),
        .out_load     (out_load),
        .out_result   (out_result)
    );

    tmt_ram #(
        .WIDTH (CELL_W),
        .DEPTH (DEPTH)
    ) u_screen (
        .aclk  (aclk),
        .we    (mem_we),
        .waddr (mem_waddr),
        .wdata (mem_wdata),
        .re    (mem_re),
        .raddr (mem_raddr),
        .rdata (mem_rdata)
    );

    tmt_out_reg u_out (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .load     (out_load),
        .result   (out_result),
        .free     (out_free),
        .m_valid  (m_valid),
        .m_ready  (m_ready),
        .m_result (m_result)
    );

    assign m_read_cell  = m_result.read_cell;
    assign m_cursor_col = m_result.cursor_col;
    assign m_cursor_row = m_result.cursor_row;
    assign m_scrolled   = m_result.scrolled;

endmodule

// File: sv/tmt_checker.sv
module tmt_checker
    import tmt_pkg::*;
#(
    parameter int COLS = 80,
    parameter int ROWS = 25
) (
    input logic                   aclk,
    input logic                   aresetn,
    input logic                   s_valid,
    input logic                   s_ready,
    input logic                   m_valid,
    input logic                   m_ready,
    input logic [CELL_W-1:0]      m_read_cell,
    input logic [FIELD_COL_W-1:0] m_cursor_col,
    input logic [FIELD_ROW_W-1:0] m_cursor_row,
    input logic                   m_scrolled
);

    // A stalled result word must hold.
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_read_cell)
            && $stable(m_cursor_col) && $stable(m_cursor_row) && $stable(m_scrolled))
        else $error("result word changed while stalled");

    // The cursor reported is always on the screen.
    a_cursor_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (int'(m_cursor_col) < COLS) && (int'(m_cursor_row) < ROWS))
        else $error("cursor outside the screen");

    // A scroll leaves the cursor at the start of the last row.
    a_scroll_pos: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_scrolled |-> (m_cursor_col == '0) && (int'(m_cursor_row) == ROWS - 1))
        else $error("scroll with cursor not at start of last row");

    // Words are handled one at a time: no accept in the cycle after an accept.
    a_one_at_a_time: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> !s_ready)
        else $error("input accepted in back-to-back cycles");

endmodule

bind text_mode_terminal_cursor_unit tmt_checker #(
    .COLS (COLS),
    .ROWS (ROWS)
) u_tmt_checker (
    .aclk         (aclk),
    .aresetn      (aresetn),
    .s_valid      (s_valid),
    .s_ready      (s_ready),
    .m_valid      (m_valid),
    .m_ready      (m_ready),
    .m_read_cell  (m_read_cell),
    .m_cursor_col (m_cursor_col),
    .m_cursor_row (m_cursor_row),
    .m_scrolled   (m_scrolled)
);
